// ===== sv/substring_deletion_filter_macros.svh =====
// assertion macros shared by the substring deletion filter modules
`ifndef SUBSTRING_DELETION_FILTER_MACROS_SVH
`define SUBSTRING_DELETION_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SDF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sdf_pkg.sv =====
// shared constants and types of the substring deletion filter
`default_nettype none

package sdf_pkg;

    // longest pattern, set by the 64-bit pattern register
    localparam int MAX_PATTERN = 8;
    localparam int BYTE_W      = 8;
    localparam int PLEN_W      = 4;
    localparam int PAT_W       = MAX_PATTERN * BYTE_W;
    // counts 0..MAX_PATTERN
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    // indexes 0..MAX_PATTERN-1
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    // window holds up to MAX_PATTERN-1 bytes
    localparam int WIN_W       = $clog2(MAX_PATTERN);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PATTERN_LEN   = 1'b0,
        CFG_PATTERN_BYTES = 1'b1
    } cfg_index_t;

    // result set of one input item: a prefix of bytes plus framing
    typedef struct packed {
        logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                   cnt;
        logic                               empty;
        logic                               last;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/sdf_window.sv =====
// pending window and per-item match logic of the substring deletion filter
`default_nettype none
`include "substring_deletion_filter_macros.svh"

module sdf_window (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [sdf_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    input  logic [sdf_pkg::PLEN_W-1:0] pattern_len,
    input  logic [sdf_pkg::PAT_W-1:0]  pattern_bytes,
    output sdf_pkg::res_t              res
);
    import sdf_pkg::*;

    logic [BYTE_W-1:0] win_reg  [MAX_PATTERN-1];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN-1];
    logic [WIN_W-1:0]  count_reg;
    logic [WIN_W-1:0]  count_next;

    logic [CNT_W-1:0]  nprev;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  e;
    logic [CNT_W-1:0]  head;
    logic [CNT_W-1:0]  k;
    logic              ge;
    logic              mism;
    logic              match;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] buf_b;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat;

    // window plus new byte, effective length and first compared position
    always_comb
    begin
        nprev = {1'b0, count_reg};
        n     = nprev + CNT_W'(1);
        if (pattern_len == '0)
        begin
            len = CNT_W'(1);
        end
        else if (CNT_W'(pattern_len) > CNT_W'(MAX_PATTERN))
        begin
            len = CNT_W'(MAX_PATTERN);
        end
        else
        begin
            len = CNT_W'(pattern_len);
        end
        ge = (n >= len);
        e  = (n > len) ? (n - len) : '0;
        for (int i = 0; i < MAX_PATTERN - 1; i++)
        begin
            if (CNT_W'(i) < nprev)
            begin
                buf_b[i] = win_reg[i];
            end
            else if (CNT_W'(i) == nprev)
            begin
                buf_b[i] = in_byte;
            end
            else
            begin
                buf_b[i] = '0;
            end
        end
        buf_b[MAX_PATTERN-1] = (nprev == CNT_W'(MAX_PATTERN - 1)) ? in_byte : '0;
    end

    // parallel byte compare of the newest len bytes against the pattern
    always_comb
    begin
        logic [CNT_W-1:0] pidx;
        pat  = pattern_bytes;
        mism = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pidx = CNT_W'(i) - e;
            if ((CNT_W'(i) >= e) && (CNT_W'(i) < n) && (buf_b[i] != pat[pidx[IDX_W-1:0]]))
            begin
                mism = 1'b1;
            end
        end
        match = ge && !mism;
    end

    // emitted prefix length, new window start and result set
    always_comb
    begin
        logic [CNT_W:0] sidx;
        if (match)
        begin
            head = n;
        end
        else if (ge)
        begin
            head = e + CNT_W'(1);
        end
        else
        begin
            head = '0;
        end

        if (match)
        begin
            k = e;
        end
        else if (in_last)
        begin
            k = n;
        end
        else
        begin
            k = head;
        end

        res.bytes = buf_b;
        res.last  = in_last;
        if (in_last && (k == '0))
        begin
            res.cnt   = CNT_W'(1);
            res.empty = 1'b1;
        end
        else
        begin
            res.cnt   = k;
            res.empty = 1'b0;
        end

        for (int i = 0; i < MAX_PATTERN - 1; i++)
        begin
            sidx = {1'b0, CNT_W'(i)} + {1'b0, head};
            win_next[i] = (sidx < (CNT_W + 1)'(MAX_PATTERN)) ? buf_b[sidx[IDX_W-1:0]] : '0;
        end
        count_next = in_last ? '0 : WIN_W'(n - head);
    end

    // window fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // window bytes, valid below the fill count only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    `SDF_ASSERT_IMPL(a_res_bound, accept, res.cnt <= n, "result count exceeds window bytes")
    `SDF_ASSERT_NEXT(a_last_clears, accept && in_last, count_reg == '0, "window kept after last")
    `SDF_ASSERT_NEXT(a_idle_holds, !accept, $stable(count_reg), "window count moved while idle")

endmodule

`default_nettype wire

// ===== sv/sdf_serializer.sv =====
// result register and output of the substring deletion filter, one item per cycle while m_tready is high
`default_nettype none
`include "substring_deletion_filter_macros.svh"

module sdf_serializer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  sdf_pkg::res_t              res,
    output logic                       in_ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sdf_pkg::BYTE_W-1:0] m_tdata,   // out_byte
    output logic                       m_tuser,   // out_empty
    output logic                       m_tlast    // out_last
);
    import sdf_pkg::*;

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes_reg;
    logic                               empty_reg;
    logic                               last_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [CNT_W-1:0]                   idx_reg;
    logic [CNT_W-1:0]                   idx_next;
    logic                               take;
    logic                               last_item;

    // output handshake and refill condition
    always_comb
    begin
        m_tvalid  = (idx_reg != cnt_reg);
        take      = m_tvalid && m_tready;
        last_item = (idx_reg == (cnt_reg - CNT_W'(1)));
        in_ready  = !m_tvalid || (take && last_item);
        idx_next  = idx_reg + CNT_W'(1);
    end

    // item fields from the current read position
    always_comb
    begin
        m_tdata = empty_reg ? '0 : bytes_reg[idx_reg[IDX_W-1:0]];
        m_tuser = empty_reg;
        m_tlast = last_reg && last_item;
    end

    // item count and read position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= res.cnt;
            idx_reg <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg <= res.bytes;
            empty_reg <= res.empty;
            last_reg  <= res.last;
        end
    end

    `SDF_ASSERT_IMPL(a_idx_bound, 1'b1, idx_reg <= cnt_reg, "read position past result count")
    `SDF_ASSERT_NEXT(a_load_restart, accept, idx_reg == '0, "read position not restarted")
    `SDF_ASSERT_IMPL(a_empty_single, m_tvalid && empty_reg,
        m_tlast && (cnt_reg == CNT_W'(1)) && (m_tdata == '0), "malformed end marker item")

endmodule

`default_nettype wire

// ===== sv/substring_deletion_filter.sv =====
// top level of the substring deletion filter: config registers, window, output
//
//  channel  dir  handshake         payload
//  s_       in   tvalid/tready     tdata[7:0] in_byte, tlast in_last
//  m_       out  tvalid/tready     tdata[7:0] out_byte, tuser out_empty, tlast out_last
//  cfg_     in   we                index 0 pattern_len, 1 pattern_bytes, data[63:0]
//
// an input byte that yields k result items occupies the result register until
// its items are taken; steady text with one item per byte runs at one byte a cycle while m_tready stays high
// s_tready follows the result register: free, or its final item taken this cycle
// reset empties the window, sets pattern_len to 1 and the pattern to zero
// a stalled m_ side holds the result register and with it s_tready
`default_nettype none

module substring_deletion_filter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sdf_pkg::BYTE_W-1:0] s_tdata,   // in_byte
    input  logic                       s_tlast,   // in_last
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sdf_pkg::BYTE_W-1:0] m_tdata,   // out_byte
    output logic                       m_tuser,   // out_empty
    output logic                       m_tlast,   // out_last
    input  logic                       cfg_we,
    input  sdf_pkg::cfg_index_t        cfg_index,
    input  logic [sdf_pkg::PAT_W-1:0]  cfg_data
);
    import sdf_pkg::*;

    logic [PLEN_W-1:0] pattern_len_reg;
    logic [PAT_W-1:0]  pattern_bytes_reg;
    logic              accept;
    res_t              res;

    assign accept = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg   <= PLEN_W'(1);
            pattern_bytes_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LEN:   pattern_len_reg   <= cfg_data[PLEN_W-1:0];
                CFG_PATTERN_BYTES: pattern_bytes_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // window and match
    sdf_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (s_tdata),
        .in_last       (s_tlast),
        .pattern_len   (pattern_len_reg),
        .pattern_bytes (pattern_bytes_reg),
        .res           (res)
    );

    // result register and output
    sdf_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .res      (res),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench of the substring deletion filter: predictor, driver, monitor
`timescale 1ns / 1ps

module testbench;

    import sdf_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int QUIET_LIMIT  = 1000;
    localparam int STALL_CYCLES = 80;
    localparam int TEXT_TARGET  = 210;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_last;
    } text_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              empty;
        logic              is_last;
    } filt_item_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    cfg_index_t        cfg_index = CFG_PATTERN_LEN;
    logic [PAT_W-1:0]  cfg_data  = '0;

    // text waiting for the driver, and filtered items still owed by the block
    text_item_t  text_queue[$];
    filt_item_t  expected_text[$];

    // shadow of the block: window and registers
    logic [BYTE_W-1:0] win_bytes [MAX_PATTERN];
    int                win_count;
    logic [PLEN_W-1:0] pat_len_reg;
    logic [PAT_W-1:0]  pat_reg;

    int   mismatch_count = 0;
    int   items_queued   = 0;
    int   quiet_cycles   = 0;
    bit   burst_mode     = 1'b0;
    bit   stall_req      = 1'b0;
    bit   stall_done     = 1'b0;
    int   stall_left     = 0;
    logic [BYTE_W-1:0] alphabet [3];

    substring_deletion_filter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // in_byte
        .s_tlast  (s_tlast),    // in_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_byte
        .m_tuser  (m_tuser),    // out_empty
        .m_tlast  (m_tlast),    // out_last
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // pattern length as the block uses it: zero acts as one, above the maximum as the maximum
    function automatic int used_len(input logic [PLEN_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(raw);
    endfunction

    // filtered items caused by one accepted text byte, window updated
    function automatic void predict_filter(input logic [BYTE_W-1:0] in_data, input logic in_last);
        logic [BYTE_W-1:0] span [MAX_PATTERN+1];
        filt_item_t        step_out[$];
        int                n;
        int                head;
        int                len;
        bit                hit;

        n    = (win_count > MAX_PATTERN - 1) ? MAX_PATTERN - 1 : win_count;
        head = 0;
        len  = used_len(pat_len_reg);
        for (int i = 0; i < n; i++)
            span[i] = win_bytes[i];
        span[n] = in_data;
        n++;
        // length cut below the window: oldest bytes leave first
        while (n - head > len) begin
            step_out.push_back('{data: span[head], empty: 1'b0, is_last: 1'b0});
            head++;
        end
        if (n - head == len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (span[head+i] != pat_reg[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                head = n;
            end
            else begin
                step_out.push_back('{data: span[head], empty: 1'b0, is_last: 1'b0});
                head++;
            end
        end
        if (in_last) begin
            // flush the window; an end marker alone when nothing is left
            while (head < n) begin
                step_out.push_back('{data: span[head], empty: 1'b0, is_last: 1'b0});
                head++;
            end
            if (step_out.size() == 0)
                step_out.push_back('{data: '0, empty: 1'b1, is_last: 1'b1});
            else
                step_out[step_out.size()-1].is_last = 1'b1;
            win_count = 0;
        end
        else begin
            for (int i = 0; i < n - head; i++)
                win_bytes[i] = span[head+i];
            win_count = n - head;
        end
        foreach (step_out[i])
            expected_text.push_back(step_out[i]);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // register write on the config port, shadow kept in step
    task automatic write_reg(input cfg_index_t idx, input logic [PAT_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_PATTERN_LEN)
            pat_len_reg = value[PLEN_W-1:0];
        else
            pat_reg = value;
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic is_last);
        text_queue.push_back('{data: data, is_last: is_last});
        items_queued++;
    endtask

    // everything sent and answered, then a settling wait for the result register
    task automatic wait_drained(input int settle);
        do
            @(negedge clk);
        while (text_queue.size() != 0 || s_tvalid || expected_text.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    // text rich in pattern occurrences and near misses
    task automatic queue_text(input int n_bytes, input bit close_frame);
        text_item_t frame[$];
        int         len;
        int         cut;

        len = used_len(pat_len_reg);
        while (frame.size() < n_bytes) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    for (int i = 0; i < len; i++)
                        frame.push_back('{data: pat_reg[8*i +: 8], is_last: 1'b0});
                end
                4, 5: begin
                    cut = $urandom_range(len);
                    for (int i = 0; i < cut; i++)
                        frame.push_back('{data: pat_reg[8*i +: 8], is_last: 1'b0});
                end
                6, 7: frame.push_back('{data: alphabet[$urandom_range(2)], is_last: 1'b0});
                default: frame.push_back('{data: BYTE_W'($urandom_range(255)), is_last: 1'b0});
            endcase
        end
        if (close_frame)
            frame[frame.size()-1].is_last = 1'b1;
        foreach (frame[i])
            queue_byte(frame[i].data, frame[i].is_last);
    endtask

    // driver: one text item per handshake, random gaps outside burst mode
    always @(posedge clk) begin : drive_text
        text_item_t nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready)
                predict_filter(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (text_queue.size() != 0 && (burst_mode || $urandom_range(99) >= 28)) begin
                    nxt = text_queue.pop_front();
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.is_last;
                    s_tvalid <= 1'b1;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready: random stalls outside burst mode plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (stall_req && !stall_done) begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= burst_mode || ($urandom_range(99) >= 28);
            end
        end
    end

    // monitor: each filtered item against the oldest expectation
    always @(posedge clk) begin : check_text
        filt_item_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("item with nothing expected: byte %02h empty %0b last %0b",
                                          m_tdata, m_tuser, m_tlast));
            end
            else begin
                want = expected_text.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.empty || m_tlast !== want.is_last)
                    report_mismatch($sformatf(
                        "byte %02h empty %0b last %0b, expected byte %02h empty %0b last %0b",
                        m_tdata, m_tuser, m_tlast, want.data, want.empty, want.is_last));
            end
        end
    end

    // watchdog on cycles without any handshake or register write
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** substring_deletion_filter: FAILED **");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin : run_text
        int               phase;
        int               frames;
        logic [PLEN_W-1:0] len_pick;
        logic [PAT_W-1:0]  pat_pick;
        bit               keep_open;

        win_count   = 0;
        pat_len_reg = 1;
        pat_reg     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern: a single zero byte is deleted
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained(8);

        // three-byte pattern with overlapping near miss
        write_reg(CFG_PATTERN_LEN, 3);
        write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0043_4241);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b0);
        queue_byte(8'h43, 1'b0);
        queue_byte(8'h43, 1'b1);
        wait_drained(8);

        // zero length acts as one
        write_reg(CFG_PATTERN_LEN, 0);
        write_reg(CFG_PATTERN_BYTES, '1);
        queue_byte(8'hFF, 1'b1);
        wait_drained(8);

        // length above the maximum acts as the maximum
        write_reg(CFG_PATTERN_LEN, 15);
        for (int i = 0; i < MAX_PATTERN; i++)
            queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b1);
        wait_drained(8);

        // full window, then length cut to one: eight items from one byte
        for (int i = 0; i < MAX_PATTERN - 1; i++)
            queue_byte(8'h11, 1'b0);
        wait_drained(8);
        write_reg(CFG_PATTERN_LEN, 1);
        write_reg(CFG_PATTERN_BYTES, '0);
        queue_byte(8'h22, 1'b1);
        wait_drained(8);

        // random phases, each with fresh settings; frames may stay open across them
        phase = 0;
        while (items_queued < TEXT_TARGET) begin
            foreach (alphabet[i])
                alphabet[i] = BYTE_W'($urandom_range(255));
            case ($urandom_range(9))
                0:       len_pick = 0;
                1:       len_pick = PLEN_W'($urandom_range(15, MAX_PATTERN + 1));
                2:       len_pick = PLEN_W'(MAX_PATTERN);
                default: len_pick = PLEN_W'($urandom_range(MAX_PATTERN, 1));
            endcase
            for (int i = 0; i < MAX_PATTERN; i++)
                pat_pick[8*i +: 8] = alphabet[$urandom_range(2)];
            write_reg(CFG_PATTERN_LEN, len_pick);
            write_reg(CFG_PATTERN_BYTES, pat_pick);

            if (phase == 1)
                burst_mode = 1'b1;
            if (phase == 3) begin
                // receiver holds off while a long text keeps coming
                queue_text(40, 1'b1);
                stall_req = 1'b1;
            end
            else if (phase == 1) begin
                // long text with no gaps on either side
                queue_text(48, 1'b1);
            end
            else begin
                frames = $urandom_range(3, 1);
                for (int f = 0; f < frames; f++) begin
                    keep_open = (f == frames - 1) && ($urandom_range(1) == 0);
                    queue_text($urandom_range(14, 1), !keep_open);
                end
            end
            wait_drained(8);
            burst_mode = 1'b0;
            phase++;
        end

        wait_drained(20);
        if (mismatch_count == 0)
            $display("** substring_deletion_filter: PASSED **");
        else
            $display("** substring_deletion_filter: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sdf_pkg.sv
sv/sdf_window.sv
sv/sdf_serializer.sv
sv/substring_deletion_filter.sv
verif/testbench.sv
